[hdl/bmtm_pkg.sv]
// ----------------------------------------------------------------------------
// bmtm_pkg
// Field widths, beat layout and status codes shared by the tag matcher files.
// ----------------------------------------------------------------------------
package bmtm_pkg;

  // input field widths
  localparam int SRC_W  = 16;
  localparam int DST_W  = 16;
  localparam int TYPE_W = 8;
  localparam int TAG_W  = 16;
  localparam int LEN_W  = 14;
  localparam int THR_W  = 4;

  // result field widths
  localparam int IDX_W  = 6;
  localparam int OFF_W  = 13;
  localparam int PLEN_W = 14;
  localparam int ST_W   = 3;

  // packed beat widths, padded to whole bytes
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOMATCH  = 3'd1,
    ST_NOBATCH  = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

endpackage

[hdl/bmtm_ram.sv]
// ----------------------------------------------------------------------------
// bmtm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bmtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/batch_message_tag_matcher.sv]
// ----------------------------------------------------------------------------
// batch_message_tag_matcher
// Receiver-side matcher: loads a batch of message headers into a table and
// answers per-thread match requests against it in table order.
// ----------------------------------------------------------------------------
// Usage: every input beat gives exactly one result beat. in_tuser selects the
// beat kind: 0 loads one header (in_tlast closes the batch), 1 is a match
// request from thread thread_id. Headers live in an entry RAM; each thread's
// consumed bitmap is one row of a second RAM, with a valid bit per row so
// that a cleared row reads as zero.
// Flow: a load goes through S_LOAD and S_EMIT into the result register.
// A request goes through S_REQ and S_SCAN, which reads the entry RAM once per
// cycle in table order up to and including the deciding entry (1 to
// MAX_ENTRIES entries), then S_EMIT. Requests rejected in S_REQ skip S_SCAN.
// One item is in work at a time; in_tready is high whenever no item is in
// work, also while an earlier result waits in the output register, so the
// next beat is taken the cycle after a result is registered.
// When the receiver stalls, a finished result waits in a holding register
// until the output register frees up; the next item is taken once it leaves.
// Reset (and completion of a batch) empties the table, the bitmaps and the
// byte counters at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module batch_message_tag_matcher #(
  parameter int MAX_ENTRIES  = 64,
  parameter int BUFFER_BYTES = 8192,
  parameter int THREADS      = 16,
  parameter int HEADER_BYTES = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // src_rank[15:0], dst_rank[31:16], type_code[39:32], msg_tag[55:40],
  // length_bytes[69:56], thread_id[73:70], zero pad
  input  logic [bmtm_pkg::IN_DATA_W-1:0]    in_tdata,
  // mode
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // entry_index[5:0], payload_offset[18:6], payload_length[32:19], zero pad
  output logic [bmtm_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status
  output logic [bmtm_pkg::ST_W-1:0]         out_tuser,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready
);

  import bmtm_pkg::*;

  localparam int IW   = $clog2(MAX_ENTRIES);
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int TW   = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int BW   = $clog2(BUFFER_BYTES + 1);
  localparam int SW   = ((BW > LEN_W) ? BW : LEN_W) + 2;
  localparam int CW   = $clog2(THREADS * BUFFER_BYTES + 1);
  localparam int EW   = SRC_W + DST_W + TYPE_W + TAG_W + LEN_W + BW;
  localparam int PADW = OUT_DATA_W - IDX_W - OFF_W - PLEN_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_REQ,
    S_SCAN,
    S_EMIT
  } state_t;

  // registers
  state_t               state_r, state_nxt;
  logic [SRC_W-1:0]     src_r, src_nxt;
  logic [DST_W-1:0]     dst_r, dst_nxt;
  logic [TYPE_W-1:0]    type_r, type_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [THR_W-1:0]     thr_r, thr_nxt;
  logic                 last_r, last_nxt;
  logic [CNTW-1:0]      entry_count_r, entry_count_nxt;
  logic [BW-1:0]        batch_bytes_r, batch_bytes_nxt;
  logic [CW-1:0]        consumed_r, consumed_nxt;
  logic                 closed_r, closed_nxt;
  logic [THREADS-1:0]   row_valid_r, row_valid_nxt;
  logic [IW-1:0]        scan_idx_r, scan_idx_nxt;
  status_t              res_st_r, res_st_nxt;
  logic [IW-1:0]        res_idx_r, res_idx_nxt;
  logic [BW-1:0]        res_off_r, res_off_nxt;
  logic [LEN_W-1:0]     res_len_r, res_len_nxt;
  logic                 res_done_r, res_done_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [ST_W-1:0]      out_tuser_r, out_tuser_nxt;
  logic                 out_tlast_r, out_tlast_nxt;

  // ram ports
  logic                 ent_we, ent_re;
  logic [IW-1:0]        ent_waddr, ent_raddr;
  logic [EW-1:0]        ent_wdata, ent_rdata;
  logic                 bm_we, bm_re;
  logic [TW-1:0]        bm_waddr, bm_raddr;
  logic [MAX_ENTRIES-1:0] bm_wdata, bm_rdata;

  // decoded entry read data
  logic [SRC_W-1:0]     e_src;
  logic [DST_W-1:0]     e_dst;
  logic [TYPE_W-1:0]    e_type;
  logic [TAG_W-1:0]     e_tag;
  logic [LEN_W-1:0]     e_len;
  logic [BW-1:0]        e_off;

  // working values
  logic                 in_acc;
  logic [TW-1:0]        thr_row;
  logic                 thr_ok;
  logic [SW-1:0]        load_total;
  logic [BW-1:0]        load_off;
  logic                 load_reject;
  logic [MAX_ENTRIES-1:0] bm_row;
  logic                 key_eq;
  logic                 scan_last;
  logic [CW-1:0]        cons_sum;
  logic                 cons_done;
  logic                 emit_go;

  bmtm_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ent_we),
    .wr_addr (ent_waddr),
    .wr_data (ent_wdata),
    .rd_en   (ent_re),
    .rd_addr (ent_raddr),
    .rd_data (ent_rdata)
  );

  bmtm_ram #(
    .WIDTH (MAX_ENTRIES),
    .DEPTH (THREADS)
  ) u_bitmap_ram (
    .clk     (clk),
    .wr_en   (bm_we),
    .wr_addr (bm_waddr),
    .wr_data (bm_wdata),
    .rd_en   (bm_re),
    .rd_addr (bm_raddr),
    .rd_data (bm_rdata)
  );

  // handshake and entry decode
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign {e_src, e_dst, e_type, e_tag, e_len, e_off} = ent_rdata;

  // thread row selection
  assign thr_ok  = (32'(thr_r) < THREADS);
  assign thr_row = TW'(thr_r);

  // load bookkeeping
  assign load_total  = SW'(batch_bytes_r) + SW'(HEADER_BYTES) + SW'(len_r);
  assign load_off    = BW'(SW'(batch_bytes_r) + SW'(HEADER_BYTES));
  assign load_reject = closed_r || (entry_count_r >= CNTW'(MAX_ENTRIES)) ||
                       (load_total > SW'(BUFFER_BYTES));

  // scan compare on the entry just read
  assign bm_row    = (thr_ok && row_valid_r[thr_row]) ? bm_rdata : '0;
  assign key_eq    = !bm_row[scan_idx_r] && (e_src == src_r) && (e_dst == dst_r) &&
                     (e_type == type_r) && (e_tag == tag_r);
  assign scan_last = (CNTW'(scan_idx_r) == entry_count_r - CNTW'(1));
  assign cons_sum  = consumed_r + CW'(HEADER_BYTES) + CW'(e_len);
  assign cons_done = (cons_sum == CW'(batch_bytes_r));

  // ram write data and addresses
  assign ent_waddr = entry_count_r[IW-1:0];
  assign ent_wdata = {src_r, dst_r, type_r, tag_r, len_r, load_off};
  assign bm_waddr  = thr_row;
  assign bm_raddr  = thr_row;
  assign bm_wdata  = bm_row | (MAX_ENTRIES'(1) << scan_idx_r);

  assign emit_go = !out_tvalid_r || out_tready;

  // next-state logic
  always_comb begin
    state_nxt       = state_r;
    src_nxt         = src_r;
    dst_nxt         = dst_r;
    type_nxt        = type_r;
    tag_nxt         = tag_r;
    len_nxt         = len_r;
    thr_nxt         = thr_r;
    last_nxt        = last_r;
    entry_count_nxt = entry_count_r;
    batch_bytes_nxt = batch_bytes_r;
    consumed_nxt    = consumed_r;
    closed_nxt      = closed_r;
    row_valid_nxt   = row_valid_r;
    scan_idx_nxt    = scan_idx_r;
    res_st_nxt      = res_st_r;
    res_idx_nxt     = res_idx_r;
    res_off_nxt     = res_off_r;
    res_len_nxt     = res_len_r;
    res_done_nxt    = res_done_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_tdata_nxt   = out_tdata_r;
    out_tuser_nxt   = out_tuser_r;
    out_tlast_nxt   = out_tlast_r;
    ent_we          = 1'b0;
    ent_re          = 1'b0;
    ent_raddr       = scan_idx_r + IW'(1);
    bm_we           = 1'b0;
    bm_re           = 1'b0;

    unique case (state_r)
      // take one beat
      S_IDLE: begin
        if (in_acc) begin
          src_nxt   = in_tdata[15:0];
          dst_nxt   = in_tdata[31:16];
          type_nxt  = in_tdata[39:32];
          tag_nxt   = in_tdata[55:40];
          len_nxt   = in_tdata[69:56];
          thr_nxt   = in_tdata[73:70];
          last_nxt  = in_tlast;
          state_nxt = in_tuser ? S_REQ : S_LOAD;
        end
      end

      // append one header to the table, or reject it as an overflow
      S_LOAD: begin
        res_done_nxt = 1'b0;
        if (load_reject) begin
          res_st_nxt  = ST_OVERFLOW;
          res_idx_nxt = '0;
          res_off_nxt = '0;
          res_len_nxt = '0;
        end else begin
          ent_we          = 1'b1;
          res_st_nxt      = ST_OK;
          res_idx_nxt     = entry_count_r[IW-1:0];
          res_off_nxt     = load_off;
          res_len_nxt     = len_r;
          batch_bytes_nxt = BW'(load_total);
          entry_count_nxt = entry_count_r + CNTW'(1);
          closed_nxt      = closed_r || last_r;
        end
        state_nxt = S_EMIT;
      end

      // request checks, then start the scan
      S_REQ: begin
        res_idx_nxt  = '0;
        res_off_nxt  = '0;
        res_len_nxt  = '0;
        res_done_nxt = 1'b0;
        priority if (!closed_r) begin
          res_st_nxt = ST_NOBATCH;
          state_nxt  = S_EMIT;
        end else if (!thr_ok) begin
          res_st_nxt = ST_NOMATCH;
          state_nxt  = S_EMIT;
        end else begin
          ent_re       = 1'b1;
          ent_raddr    = '0;
          bm_re        = 1'b1;
          scan_idx_nxt = '0;
          state_nxt    = S_SCAN;
        end
      end

      // one entry per cycle, next read issued ahead
      S_SCAN: begin
        ent_re = 1'b1;
        priority if (key_eq && (e_len != len_r)) begin
          res_st_nxt   = ST_MISMATCH;
          res_idx_nxt  = scan_idx_r;
          res_off_nxt  = e_off;
          res_len_nxt  = e_len;
          res_done_nxt = 1'b0;
          state_nxt    = S_EMIT;
        end else if (key_eq) begin
          bm_we        = 1'b1;
          res_st_nxt   = ST_OK;
          res_idx_nxt  = scan_idx_r;
          res_off_nxt  = e_off;
          res_len_nxt  = e_len;
          res_done_nxt = cons_done;
          state_nxt    = S_EMIT;
          if (cons_done) begin
            entry_count_nxt = '0;
            batch_bytes_nxt = '0;
            consumed_nxt    = '0;
            closed_nxt      = 1'b0;
            row_valid_nxt   = '0;
          end else begin
            consumed_nxt           = cons_sum;
            row_valid_nxt[thr_row] = 1'b1;
          end
        end else if (scan_last) begin
          res_st_nxt   = ST_NOMATCH;
          res_idx_nxt  = '0;
          res_off_nxt  = '0;
          res_len_nxt  = '0;
          res_done_nxt = 1'b0;
          state_nxt    = S_EMIT;
        end else begin
          scan_idx_nxt = scan_idx_r + IW'(1);
        end
      end

      // move the result into the output register
      S_EMIT: begin
        if (emit_go) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = res_st_r;
          out_tlast_nxt  = res_done_r;
          out_tdata_nxt  = {{PADW{1'b0}}, PLEN_W'(res_len_r), OFF_W'(res_off_r),
                            IDX_W'(res_idx_r)};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      batch_bytes_r <= '0;
      consumed_r    <= '0;
      closed_r      <= 1'b0;
      row_valid_r   <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      src_r         <= src_nxt;
      dst_r         <= dst_nxt;
      type_r        <= type_nxt;
      tag_r         <= tag_nxt;
      len_r         <= len_nxt;
      thr_r         <= thr_nxt;
      last_r        <= last_nxt;
      entry_count_r <= entry_count_nxt;
      batch_bytes_r <= batch_bytes_nxt;
      consumed_r    <= consumed_nxt;
      closed_r      <= closed_nxt;
      row_valid_r   <= row_valid_nxt;
      scan_idx_r    <= scan_idx_nxt;
      res_st_r      <= res_st_nxt;
      res_idx_r     <= res_idx_nxt;
      res_off_r     <= res_off_nxt;
      res_len_r     <= res_len_nxt;
      res_done_r    <= res_done_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
      out_tdata_r   <= out_tdata_nxt;
      out_tuser_r   <= out_tuser_nxt;
      out_tlast_r   <= out_tlast_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

[hdl/bmtm_checker.sv]
// ----------------------------------------------------------------------------
// bmtm_checker
// Port-level checks on the tag matcher, bound to every instance of it.
// ----------------------------------------------------------------------------
module bmtm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [bmtm_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [bmtm_pkg::ST_W-1:0]       out_tuser,
  input logic                            out_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready
);

  import bmtm_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while an item is in work");

  // status stays within the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ST_OVERFLOW)
    else $error("undefined status code");

  // batch completion only on a successful match
  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == ST_OK)
    else $error("batch done without a match");

  // rejected beats carry empty fields
  a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_NOMATCH || out_tuser == ST_NOBATCH ||
                   out_tuser == ST_OVERFLOW) |-> out_tdata == '0 && !out_tlast)
    else $error("rejected result carries data");

endmodule

bind batch_message_tag_matcher bmtm_checker u_bmtm_checker (.*);
